### src/dah_pkg.sv
// Shared types, constants and the CORDIC angle table for the dual antenna heading unit.
package dah_pkg;

  // Signed width of one antenna difference after interpolation
  localparam int DW = 60;
  // Dividend width of the rounding divider
  localparam int NW = 59;
  // Width of the CORDIC x and y registers
  localparam int CW = 34;
  // Step counts of the serial units
  localparam int MUL_N    = 33;
  localparam int SQRT_N   = 32;
  localparam int CORDIC_N = 24;

  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;
  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_MAIN_GAP  = 3'd1;
  localparam logic [2:0] STAT_SUB_LAG   = 3'd2;
  localparam logic [2:0] STAT_MAIN_POOR = 3'd3;
  localparam logic [2:0] STAT_SUB_POOR  = 3'd4;
  localparam logic [2:0] STAT_OUTLIER   = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_GAP  = 3'd0;
  localparam logic [2:0] CFG_MAX_LAG  = 3'd1;
  localparam logic [2:0] CFG_BIAS     = 3'd2;
  localparam logic [2:0] CFG_NOMINAL  = 3'd3;
  localparam logic [2:0] CFG_TOL      = 3'd4;
  localparam logic [2:0] CFG_OCHK     = 3'd5;
  localparam logic [2:0] CFG_QMIN     = 3'd6;
  localparam logic [2:0] CFG_QMAX     = 3'd7;

  typedef struct packed {
    logic [23:0] max_gap;
    logic [23:0] max_lag;
    logic [15:0] bias;
    logic [19:0] nom;
    logic [19:0] tol;
    logic        ochk;
    logic [3:0]  qmin;
    logic [3:0]  qmax;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [39:0]        t;
    logic               v;
  } fix_t;

  typedef struct packed {
    logic signed [31:0]    px;
    logic signed [31:0]    py;
    logic signed [31:0]    pz;
    logic [39:0]           t;
    logic [3:0]            qual;
    logic [23:0]           lag;
    logic [23:0]           gap;
    logic                  dneg;
    logic                  neg;
    logic [2:0]            stat;
    logic [1:0]            axis;
    logic signed [32:0]    pc;
    logic [63:0]           mcand;
    logic [32:0]           mplier;
    logic [63:0]           acc;
    logic [5:0]            cnt;
    logic                  is_sq;
    logic [NW-1:0]         num;
    logic [24:0]           rem;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;
    logic [63:0]           sum;
    logic                  sovf;
    logic [63:0]           root;
    logic [63:0]           srem;
    logic [31:0]           base;
    logic [DW-1:0]         cx;
    logic [DW-1:0]         cy;
    logic                  zero;
    logic signed [CW-1:0]  xr;
    logic signed [CW-1:0]  yr;
    logic signed [31:0]    z;
    logic [15:0]           yaw;
  } work_t;

  // Magnitude of a signed difference
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // atan(2^-i) with 2^32 per turn
  function automatic logic [31:0] cordic_atan(input logic [4:0] i);
    unique case (i)
      5'd0:    cordic_atan = 32'd536870912;
      5'd1:    cordic_atan = 32'd316933406;
      5'd2:    cordic_atan = 32'd167458907;
      5'd3:    cordic_atan = 32'd85004756;
      5'd4:    cordic_atan = 32'd42667331;
      5'd5:    cordic_atan = 32'd21354465;
      5'd6:    cordic_atan = 32'd10679838;
      5'd7:    cordic_atan = 32'd5340245;
      5'd8:    cordic_atan = 32'd2670163;
      5'd9:    cordic_atan = 32'd1335087;
      5'd10:   cordic_atan = 32'd667544;
      5'd11:   cordic_atan = 32'd333772;
      5'd12:   cordic_atan = 32'd166886;
      5'd13:   cordic_atan = 32'd83443;
      5'd14:   cordic_atan = 32'd41722;
      5'd15:   cordic_atan = 32'd20861;
      5'd16:   cordic_atan = 32'd10430;
      5'd17:   cordic_atan = 32'd5215;
      5'd18:   cordic_atan = 32'd2608;
      5'd19:   cordic_atan = 32'd1304;
      5'd20:   cordic_atan = 32'd652;
      5'd21:   cordic_atan = 32'd326;
      5'd22:   cordic_atan = 32'd163;
      5'd23:   cordic_atan = 32'd81;
      default: cordic_atan = 32'd0;
    endcase
  endfunction

endpackage

### src/dual_antenna_heading_unit.sv
// A main fix is absorbed in the cycle it is accepted and gives no beat. A sub fix that fails
// a gate goes from the gate state straight to the final state; one that passes works through
// the shared serial multiplier (up to six products), the bit-serial divider (once per axis),
// the square root, the normalizing shifter and 24 CORDIC steps, some skipped on a saturated
// baseline or a zero vector. One item is in work at a time.
// Reset clears history, skip count and the output valid flag and loads register defaults.
module dual_antenna_heading_unit
  import dah_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], time_us[135:96], quality[139:136], zero pad
  input  logic [143:0] s_axis_tdata,
  // mode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // yaw[15:0], baseline_mm[47:16], antenna_x[79:48], antenna_y[111:80],
  // antenna_z[143:112], skip_total[159:144]
  output logic [159:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GATE = 4'd1;
  localparam logic [3:0] S_AXIS = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DIVI = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_ADJ  = 4'd6;
  localparam logic [3:0] S_BASE = 4'd7;
  localparam logic [3:0] S_SQN  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_SQRF = 4'd10;
  localparam logic [3:0] S_ANG  = 4'd11;
  localparam logic [3:0] S_NORM = 4'd12;
  localparam logic [3:0] S_CORD = 4'd13;
  localparam logic [3:0] S_YAW  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0]   state_q, state_d;
  cfg_t         cfg_q, cfg_d;
  fix_t         cur_q, cur_d, prv_q, prv_d;
  logic [15:0]  skip_q, skip_d;
  logic         ov_q, ov_d;
  work_t        w_q, w_d;
  logic [159:0] odata_q, odata_d;
  logic [2:0]   ouser_q, ouser_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  always_comb begin
    logic [3:0]           in_q;
    logic                 in_qok, sub_qok;
    logic [40:0]          dmt, lag41;
    logic [39:0]          gap40;
    logic signed [31:0]   cur_s, old_s, p_s;
    logic signed [32:0]   diff;
    logic [32:0]          adiff;
    logic [25:0]          trial;
    logic [24:0]          d2;
    logic signed [DW-1:0] dval;
    logic [DW-1:0]        mx, my, mz, msel;
    logic [64:0]          sum65;
    logic [63:0]          sbit, strial;
    logic [6:0]           sh;
    logic [32:0]          rnd;
    logic [DW-1:0]        orv;
    logic signed [CW-1:0] xs, ys;
    logic [31:0]          zc, ang, y32, y32r;
    logic signed [21:0]   lo, hi;
    logic signed [33:0]   base_s;

    state_d = state_q;
    cfg_d   = cfg_q;
    cur_d   = cur_q;
    prv_d   = prv_q;
    skip_d  = skip_q;
    w_d     = w_q;
    odata_d = odata_q;
    ouser_d = ouser_q;
    ov_d    = ov_q;

    in_q    = s_axis_tdata[139:136];
    in_qok  = (cfg_q.qmin <= in_q) && (in_q <= cfg_q.qmax);
    sub_qok = (cfg_q.qmin <= w_q.qual) && (w_q.qual <= cfg_q.qmax);

    dmt    = {1'b0, cur_q.t} - {1'b0, prv_q.t};
    gap40  = dmt[40] ? (~dmt[39:0] + 40'd1) : dmt[39:0];
    lag41  = {1'b0, w_q.t} - {1'b0, cur_q.t};

    unique case (w_q.axis)
      2'd0:    begin cur_s = cur_q.x; old_s = prv_q.x; p_s = w_q.px; end
      2'd1:    begin cur_s = cur_q.y; old_s = prv_q.y; p_s = w_q.py; end
      default: begin cur_s = cur_q.z; old_s = prv_q.z; p_s = w_q.pz; end
    endcase
    diff  = {cur_s[31], cur_s} - {old_s[31], old_s};
    adiff = diff[32] ? 33'(-diff) : 33'(diff);

    d2    = {w_q.gap, 1'b0};
    trial = {w_q.rem, w_q.num[NW-1]};
    dval  = w_q.neg ? (DW'(w_q.pc) + $signed({1'b0, w_q.num}))
                    : (DW'(w_q.pc) - $signed({1'b0, w_q.num}));

    mx = mag(w_q.dx);
    my = mag(w_q.dy);
    mz = mag(w_q.dz);
    unique case (w_q.axis)
      2'd0:    msel = mx;
      2'd1:    msel = my;
      default: msel = mz;
    endcase
    sum65 = {1'b0, w_q.sum} + {1'b0, w_q.acc};

    sh     = 7'd62 - {w_q.cnt, 1'b0};
    sbit   = 64'd1 << sh;
    strial = w_q.root + sbit;
    rnd    = w_q.root[32:0] + ((w_q.srem > w_q.root) ? 33'd1 : 33'd0);

    orv = w_q.cx | w_q.cy;
    xs  = w_q.xr >>> w_q.cnt[4:0];
    ys  = w_q.yr >>> w_q.cnt[4:0];

    // clamp the first quadrant angle, then fold it into place
    if (w_q.zero || w_q.z < 0)       zc = 32'd0;
    else if (w_q.z > $signed(QUARTER)) zc = QUARTER;
    else                              zc = w_q.z;
    if (!w_q.dy[DW-1]) ang = w_q.dx[DW-1] ? (32'd0 - zc) : zc;
    else               ang = w_q.dx[DW-1] ? (zc - HALF) : (HALF - zc);
    if (w_q.zero) ang = 32'd0;
    y32    = {cfg_q.bias, 16'd0} - ang;
    y32r   = y32 + 32'h0000_8000;
    lo     = $signed({2'b00, cfg_q.nom}) - $signed({2'b00, cfg_q.tol});
    hi     = $signed({2'b00, cfg_q.nom}) + $signed({2'b00, cfg_q.tol});
    base_s = $signed({2'b00, w_q.base});

    // drop the output beat once taken
    if (m_axis_tready) ov_d = 1'b0;

    // register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_GAP: cfg_d.max_gap = cfg_data_i;
        CFG_MAX_LAG: cfg_d.max_lag = cfg_data_i;
        CFG_BIAS:    cfg_d.bias    = cfg_data_i[15:0];
        CFG_NOMINAL: cfg_d.nom     = cfg_data_i[19:0];
        CFG_TOL:     cfg_d.tol     = cfg_data_i[19:0];
        CFG_OCHK:    cfg_d.ochk    = cfg_data_i[0];
        CFG_QMIN:    cfg_d.qmin    = cfg_data_i[3:0];
        CFG_QMAX:    cfg_d.qmax    = cfg_data_i[3:0];
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            // shift the main fix history if its quality is in range
            if (in_qok) begin
              prv_d   = cur_q;
              cur_d.x = s_axis_tdata[31:0];
              cur_d.y = s_axis_tdata[63:32];
              cur_d.z = s_axis_tdata[95:64];
              cur_d.t = s_axis_tdata[135:96];
              cur_d.v = 1'b1;
            end
          end else begin
            w_d.px   = s_axis_tdata[31:0];
            w_d.py   = s_axis_tdata[63:32];
            w_d.pz   = s_axis_tdata[95:64];
            w_d.t    = s_axis_tdata[135:96];
            w_d.qual = in_q;
            state_d  = S_GATE;
          end
        end
      end
      S_GATE: begin
        priority if (gap40 > {16'd0, cfg_q.max_gap})                w_d.stat = STAT_MAIN_GAP;
        else if (lag41[40] || lag41[39:0] > {16'd0, cfg_q.max_lag}) w_d.stat = STAT_SUB_LAG;
        else if (!cur_q.v || !prv_q.v || gap40 == 40'd0)            w_d.stat = STAT_MAIN_POOR;
        else if (!sub_qok)                                          w_d.stat = STAT_SUB_POOR;
        else                                                        w_d.stat = STAT_OK;
        w_d.gap  = gap40[23:0];
        w_d.lag  = lag41[23:0];
        w_d.dneg = dmt[40];
        w_d.axis = 2'd0;
        w_d.base = 32'd0;
        w_d.yaw  = 16'd0;
        if (w_d.stat != STAT_OK) begin
          if (skip_q != 16'hFFFF) skip_d = skip_q + 16'd1;
          state_d = S_FIN;
        end else begin
          skip_d  = 16'd0;
          state_d = S_AXIS;
        end
      end
      S_AXIS: begin
        // load |main - prev| times lag into the multiplier
        w_d.pc     = {p_s[31], p_s} - {cur_s[31], cur_s};
        w_d.neg    = diff[32] ^ w_q.dneg;
        w_d.mcand  = {31'd0, adiff};
        w_d.mplier = {9'd0, w_q.lag};
        w_d.acc    = 64'd0;
        w_d.cnt    = 6'd0;
        w_d.is_sq  = 1'b0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        if (w_q.mplier[0]) w_d.acc = w_q.acc + w_q.mcand;
        w_d.mcand  = {w_q.mcand[62:0], 1'b0};
        w_d.mplier = {1'b0, w_q.mplier[32:1]};
        w_d.cnt    = w_q.cnt + 6'd1;
        if (w_q.cnt == 6'(MUL_N - 1)) state_d = w_q.is_sq ? S_SQN : S_DIVI;
      end
      S_DIVI: begin
        w_d.num = {1'b0, w_q.acc[NW-3:0], 1'b0} + NW'(w_q.gap);
        w_d.rem = 25'd0;
        w_d.cnt = 6'd0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, d2}) begin
          w_d.rem = 25'(trial - {1'b0, d2});
          w_d.num = {w_q.num[NW-2:0], 1'b1};
        end else begin
          w_d.rem = trial[24:0];
          w_d.num = {w_q.num[NW-2:0], 1'b0};
        end
        w_d.cnt = w_q.cnt + 6'd1;
        if (w_q.cnt == 6'(NW - 1)) state_d = S_ADJ;
      end
      S_ADJ: begin
        unique case (w_q.axis)
          2'd0:    w_d.dx = dval;
          2'd1:    w_d.dy = dval;
          default: w_d.dz = dval;
        endcase
        if (w_q.axis == 2'd2) begin
          state_d = S_BASE;
        end else begin
          w_d.axis = w_q.axis + 2'd1;
          state_d  = S_AXIS;
        end
      end
      S_BASE: begin
        w_d.acc  = 64'd0;
        w_d.sum  = 64'd0;
        w_d.sovf = 1'b0;
        w_d.axis = 2'd0;
        if ((|mx[DW-1:32]) || (|my[DW-1:32]) || (|mz[DW-1:32])) begin
          w_d.base = SAT32;
          state_d  = S_ANG;
        end else begin
          state_d = S_SQN;
        end
      end
      S_SQN: begin
        // accumulate the last square, then start the next or the square root
        w_d.sum  = sum65[63:0];
        w_d.sovf = w_q.sovf | sum65[64];
        if (w_q.axis == 2'd3) begin
          w_d.srem = sum65[63:0];
          w_d.root = 64'd0;
          w_d.cnt  = 6'd0;
          if (w_q.sovf || sum65[64]) begin
            w_d.base = SAT32;
            state_d  = S_ANG;
          end else begin
            state_d = S_SQRT;
          end
        end else begin
          w_d.mcand  = {32'd0, msel[31:0]};
          w_d.mplier = {1'b0, msel[31:0]};
          w_d.acc    = 64'd0;
          w_d.cnt    = 6'd0;
          w_d.is_sq  = 1'b1;
          w_d.axis   = w_q.axis + 2'd1;
          state_d    = S_MUL;
        end
      end
      S_SQRT: begin
        if (w_q.srem >= strial) begin
          w_d.srem = w_q.srem - strial;
          w_d.root = {1'b0, w_q.root[63:1]} + sbit;
        end else begin
          w_d.root = {1'b0, w_q.root[63:1]};
        end
        w_d.cnt = w_q.cnt + 6'd1;
        if (w_q.cnt == 6'(SQRT_N - 1)) state_d = S_SQRF;
      end
      S_SQRF: begin
        w_d.base = rnd[32] ? SAT32 : rnd[31:0];
        state_d  = S_ANG;
      end
      S_ANG: begin
        w_d.cx   = my;
        w_d.cy   = mx;
        w_d.zero = (mx == '0) && (my == '0);
        state_d  = ((mx == '0) && (my == '0)) ? S_YAW : S_NORM;
      end
      S_NORM: begin
        // bring the larger magnitude into [2^29, 2^30)
        if (|orv[DW-1:30]) begin
          w_d.cx = w_q.cx >> 1;
          w_d.cy = w_q.cy >> 1;
        end else if (!orv[29]) begin
          w_d.cx = w_q.cx << 1;
          w_d.cy = w_q.cy << 1;
        end else begin
          w_d.xr  = $signed(CW'(w_q.cx[29:0]));
          w_d.yr  = $signed(CW'(w_q.cy[29:0]));
          w_d.z   = 32'sd0;
          w_d.cnt = 6'd0;
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (!w_q.yr[CW-1]) begin
          w_d.xr = w_q.xr + ys;
          w_d.yr = w_q.yr - xs;
          w_d.z  = w_q.z + $signed(cordic_atan(w_q.cnt[4:0]));
        end else begin
          w_d.xr = w_q.xr - ys;
          w_d.yr = w_q.yr + xs;
          w_d.z  = w_q.z - $signed(cordic_atan(w_q.cnt[4:0]));
        end
        w_d.cnt = w_q.cnt + 6'd1;
        if (w_q.cnt == 6'(CORDIC_N - 1)) state_d = S_YAW;
      end
      S_YAW: begin
        w_d.yaw = y32r[31:16];
        if (cfg_q.ochk && (base_s < 34'(lo) || base_s > 34'(hi))) w_d.stat = STAT_OUTLIER;
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ov_q || m_axis_tready) begin
          odata_d = {skip_q, cur_q.z, cur_q.y, cur_q.x, w_q.base, w_q.yaw};
          ouser_d = w_q.stat;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ov_q          <= 1'b0;
      skip_q        <= 16'd0;
      cur_q         <= '0;
      prv_q         <= '0;
      cfg_q.max_gap <= 24'd150000;
      cfg_q.max_lag <= 24'd100000;
      cfg_q.bias    <= 16'd0;
      cfg_q.nom     <= 20'd1000;
      cfg_q.tol     <= 20'd100;
      cfg_q.ochk    <= 1'b1;
      cfg_q.qmin    <= 4'd4;
      cfg_q.qmax    <= 4'd5;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      skip_q  <= skip_d;
      cur_q   <= cur_d;
      prv_q   <= prv_d;
      cfg_q   <= cfg_d;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

`ifndef NO_ASSERTIONS
  a_skip_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_OUTLIER)
    |-> m_axis_tdata[159:144] == 16'd0)
    else $error("skip count not cleared on a passed sub fix");

  a_gate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !(m_axis_tuser == STAT_OK || m_axis_tuser == STAT_OUTLIER)
    |-> m_axis_tdata[47:0] == 48'd0 && m_axis_tdata[159:144] != 16'd0)
    else $error("gated sub fix carries yaw, baseline or zero skip count");

  a_beat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_FIN)
    else $error("output beat raised outside the final state");
`endif

endmodule
